>>> sv/srgc_pkg.sv
package srgc_pkg;

   // Field widths of the transactions.
   localparam int OP_W      = 2;
   localparam int STREAM_W  = 8;
   localparam int VERSION_W = 8;
   localparam int SEQ_W     = 64;
   localparam int REV_W     = 64;
   localparam int STATUS_W  = 3;

   // Protocol version accepted after reset.
   localparam logic [VERSION_W-1:0] RESET_VERSION = 8'd4;

   // Global sequence number expected after reset or a tracker reset.
   localparam logic [SEQ_W-1:0] FIRST_SEQUENCE = 64'd1;

   typedef enum logic [OP_W-1:0] {
      OP_INSPECT = 2'd0,
      OP_COMMIT  = 2'd1,
      OP_RESET   = 2'd2,
      OP_QUERY   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_APPLY          = 3'd0,
      STS_STALE          = 3'd1,
      STS_GAP            = 3'd2,
      STS_UNKNOWN_KEY    = 3'd3,
      STS_BAD_HEADER     = 3'd4,
      STS_SNAP_WITH_BASE = 3'd5,
      STS_BAD_PAIR       = 3'd6
   } status_type;

endpackage

>>> sv/srgc_if.sv
// Request channel: one operation on the tracker per transaction.
interface srgc_req_if import srgc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OP_W-1:0]      operation;
   logic [STREAM_W-1:0]  stream;
   logic                 fields_known;
   logic                 well_formed;
   logic [VERSION_W-1:0] version;
   logic [SEQ_W-1:0]     sequence_req;
   logic [REV_W-1:0]     revision;
   logic                 is_snapshot;
   logic                 has_base_revision;
   logic                 base_revision_numeric;
   logic [REV_W-1:0]     base_revision;

   modport source (
      output valid, operation, stream, fields_known, well_formed, version,
             sequence_req, revision, is_snapshot, has_base_revision,
             base_revision_numeric, base_revision,
      input  ready
   );

   modport sink (
      input  valid, operation, stream, fields_known, well_formed, version,
             sequence_req, revision, is_snapshot, has_base_revision,
             base_revision_numeric, base_revision,
      output ready
   );
endinterface

// Response channel: one result per request transaction.
interface srgc_rsp_if import srgc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                send_request;
   logic [REV_W-1:0]    request_revision;
   logic [REV_W-1:0]    current_revision;

   modport source (
      output valid, status, send_request, request_revision, current_revision,
      input  ready
   );

   modport sink (
      input  valid, status, send_request, request_revision, current_revision,
      output ready
   );
endinterface

// Register write channel: carries the expected protocol version.
interface srgc_csr_if import srgc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [VERSION_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

>>> sv/srgc_ram.sv
// Simple dual-port RAM with a registered read port.
module srgc_ram #(
   parameter int WIDTH = 65,
   parameter int DEPTH = 256
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/stream_revision_gap_checker.sv
// Stream revision gap checker.
//
// Each request transaction is one operation: inspect a parsed message header,
// commit a stream revision, reset the tracker, or query a stream revision.
// Every request produces exactly one response transaction on rsp_bus. The
// expected protocol version is written through csr_bus, which is always ready;
// write it only while no request is in flight.
//
// Per-stream state (revision and pending-resync flag) lives in one RAM that
// is read when a request is accepted and written back in the execute cycle.
// A request therefore occupies the accept cycle, which issues the RAM read,
// and the execute cycle, which classifies and writes back. The response is
// presented from the cycle after the execute cycle. A new request is accepted
// only once the previous one has left the execute cycle.
// After reset, and after every reset-tracker request, the block clears the RAM
// one entry per cycle, and holds req_bus.ready low meanwhile. Register writes
// are still taken during that pass.
// The response sits in an output register. If the receiver stalls, one more
// request can still be accepted; it waits in the execute cycle until the
// output register is free.
module stream_revision_gap_checker import srgc_pkg::*; #(
   parameter int STREAMS = 256
) (
   input logic clock,
   input logic reset,
   srgc_req_if.sink   req_bus,
   srgc_rsp_if.source rsp_bus,
   srgc_csr_if.sink   csr_bus
);

   localparam int SW        = (STREAMS > 1) ? $clog2(STREAMS) : 1;
   localparam int MEM_W     = REV_W + 1;
   localparam logic [SW-1:0] LAST_SLOT = SW'(STREAMS - 1);

   // Control states, one-hot.
   typedef enum logic [2:0] {
      S_CLEAR = 3'b001,
      S_IDLE  = 3'b010,
      S_EXEC  = 3'b100
   } state_type;

   // Reduces a stream index modulo STREAMS by conditional subtraction.
   function automatic logic [SW-1:0] stream_slot(input logic [STREAM_W-1:0] s);
      logic [24:0] v;
      v = {17'd0, s};
      for (int k = STREAM_W - 1; k >= 0; k--) begin
         if (v >= (25'(STREAMS) << k)) begin
            v = v - (25'(STREAMS) << k);
         end
      end
      return v[SW-1:0];
   endfunction

   state_type            state_ff, state_in;
   logic [SW-1:0]        clr_idx_ff, clr_idx_in;
   logic [SEQ_W-1:0]     exp_seq_ff, exp_seq_in;
   logic [VERSION_W-1:0] exp_ver_ff, exp_ver_in;

   // Captured request.
   op_type               op_ff;
   logic [SW-1:0]        slot_ff;
   logic                 known_ff;
   logic                 wf_ff;
   logic [VERSION_W-1:0] ver_ff;
   logic [SEQ_W-1:0]     seq_ff;
   logic [REV_W-1:0]     rev_ff;
   logic                 snap_ff;
   logic                 has_base_ff;
   logic                 base_num_ff;
   logic [REV_W-1:0]     base_ff;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic                 rsp_send_ff, rsp_send_in;
   logic [REV_W-1:0]     rsp_req_rev_ff, rsp_req_rev_in;
   logic [REV_W-1:0]     rsp_cur_rev_ff, rsp_cur_rev_in;

   // RAM port signals.
   logic                 mem_wr_en;
   logic [SW-1:0]        mem_wr_addr;
   logic [MEM_W-1:0]     mem_wr_data;
   logic                 mem_rd_en;
   logic [MEM_W-1:0]     mem_rd_data;

   logic                 req_fire;
   logic                 exec_go;
   logic [REV_W-1:0]     cur_rev;
   logic                 pending;
   logic                 hdr_ok;
   logic [REV_W-1:0]     base_plus1;
   status_type           status_c;
   logic                 send_c;
   logic                 advance_seq;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   // The execute cycle completes once the output register can take the result.
   assign exec_go = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_bus.ready);

   assign cur_rev    = mem_rd_data[REV_W-1:0];
   assign pending    = mem_rd_data[REV_W];
   assign base_plus1 = base_ff + 64'd1;
   assign hdr_ok     = wf_ff && (ver_ff == exp_ver_ff) && (seq_ff == exp_seq_ff)
                       && (rev_ff != '0);

   // Header classification. A snapshot request goes out only on the first
   // gap seen since the last commit to the stream or the last RAM clear.
   always_comb begin
      status_c    = STS_APPLY;
      send_c      = 1'b0;
      advance_seq = 1'b0;
      if (op_ff == OP_INSPECT) begin
         if (!known_ff) begin
            status_c = STS_UNKNOWN_KEY;
         end else if (!hdr_ok) begin
            status_c = STS_BAD_HEADER;
         end else begin
            advance_seq = 1'b1;
            if (snap_ff) begin
               if (has_base_ff) begin
                  status_c = STS_SNAP_WITH_BASE;
               end else if (rev_ff <= cur_rev) begin
                  status_c = STS_STALE;
               end else begin
                  status_c = STS_APPLY;
               end
            end else if (!has_base_ff || !base_num_ff || (rev_ff != base_plus1)) begin
               status_c = STS_BAD_PAIR;
            end else if ((rev_ff <= cur_rev) || (base_ff < cur_rev)) begin
               status_c = STS_STALE;
            end else if (base_ff > cur_rev) begin
               status_c = STS_GAP;
               send_c   = !pending;
            end else begin
               status_c = STS_APPLY;
            end
         end
      end
   end

   // RAM access: clearing pass, commit write, or setting the resync flag.
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = slot_ff;
      mem_wr_data = '0;
      if (state_ff == S_CLEAR) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = clr_idx_ff;
      end else if (exec_go && (op_ff == OP_COMMIT)) begin
         mem_wr_en   = 1'b1;
         mem_wr_data = {1'b0, rev_ff};
      end else if (exec_go && send_c) begin
         mem_wr_en   = 1'b1;
         mem_wr_data = {1'b1, cur_rev};
      end
   end

   assign mem_rd_en = req_fire;

   srgc_ram #(
      .WIDTH (MEM_W),
      .DEPTH (STREAMS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (stream_slot(req_bus.stream)),
      .rd_data (mem_rd_data)
   );

   // State sequencing and tracker registers.
   always_comb begin
      state_in   = state_ff;
      clr_idx_in = clr_idx_ff;
      exp_seq_in = exp_seq_ff;
      exp_ver_in = exp_ver_ff;
      if (csr_bus.valid) begin
         exp_ver_in = csr_bus.data;
      end
      case (state_ff)
         S_CLEAR: begin
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == LAST_SLOT) begin
               clr_idx_in = '0;
               state_in   = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (exec_go) begin
               if (op_ff == OP_RESET) begin
                  state_in   = S_CLEAR;
                  clr_idx_in = '0;
                  exp_seq_in = FIRST_SEQUENCE;
               end else begin
                  state_in = S_IDLE;
                  if (advance_seq) begin
                     exp_seq_in = exp_seq_ff + 64'd1;
                  end
               end
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // Output register next values.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_send_in    = rsp_send_ff;
      rsp_req_rev_in = rsp_req_rev_ff;
      rsp_cur_rev_in = rsp_cur_rev_ff;
      if (exec_go) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = status_c;
         rsp_send_in    = send_c;
         rsp_req_rev_in = send_c ? cur_rev : '0;
         if (op_ff == OP_COMMIT) begin
            rsp_cur_rev_in = rev_ff;
         end else if (op_ff == OP_RESET) begin
            rsp_cur_rev_in = '0;
         end else begin
            rsp_cur_rev_in = cur_rev;
         end
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_idx_ff   <= '0;
         exp_seq_ff   <= FIRST_SEQUENCE;
         exp_ver_ff   <= RESET_VERSION;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         exp_seq_ff   <= exp_seq_in;
         exp_ver_ff   <= exp_ver_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_send_ff    <= rsp_send_in;
      rsp_req_rev_ff <= rsp_req_rev_in;
      rsp_cur_rev_ff <= rsp_cur_rev_in;
      if (req_fire) begin
         op_ff       <= op_type'(req_bus.operation);
         slot_ff     <= stream_slot(req_bus.stream);
         known_ff    <= req_bus.fields_known;
         wf_ff       <= req_bus.well_formed;
         ver_ff      <= req_bus.version;
         seq_ff      <= req_bus.sequence_req;
         rev_ff      <= req_bus.revision;
         snap_ff     <= req_bus.is_snapshot;
         has_base_ff <= req_bus.has_base_revision;
         base_num_ff <= req_bus.base_revision_numeric;
         base_ff     <= req_bus.base_revision;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.status           = rsp_status_ff;
   assign rsp_bus.send_request     = rsp_send_ff;
   assign rsp_bus.request_revision = rsp_req_rev_ff;
   assign rsp_bus.current_revision = rsp_cur_rev_ff;

   // A snapshot request only ever accompanies a gap status.
   a_send_only_on_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.send_request) |-> (rsp_bus.status == STS_GAP))
      else $error("snapshot request without a gap status");

   // Without a snapshot request the requested revision reads as zero.
   a_req_rev_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.send_request) |-> (rsp_bus.request_revision == '0))
      else $error("request revision set without a snapshot request");

   // An accepted request always moves into the execute cycle.
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_EXEC))
      else $error("accepted request did not enter the execute cycle");

   // A completed tracker reset restarts the sequence and starts a clearing pass.
   a_reset_op_clears: assert property (@(posedge clock) disable iff (reset)
      (exec_go && (op_ff == OP_RESET)) |=>
         ((exp_seq_ff == FIRST_SEQUENCE) && (state_ff == S_CLEAR) && (clr_idx_ff == '0)))
      else $error("tracker reset did not restart the tracker");

endmodule
